// File: rtl/csvp_pkg.sv
`timescale 1ns / 1ps
package csvp_pkg;

	localparam int COLS_W = 7;
	localparam logic [COLS_W-1:0] COLS_RESET = 7'd2;
	localparam logic [COLS_W-1:0] COUNT_SAT = 7'd127;
	localparam logic [31:0] VALUE_MAX = 32'd255;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [1:0] ST_PAIR = 2'd0;
	localparam logic [1:0] ST_VALUE = 2'd1;
	localparam logic [1:0] ST_WIDTH = 2'd2;
	localparam logic [1:0] ST_END = 2'd3;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_stream;
	} in_t;

	typedef struct packed {
		logic [7:0] first_pixel;
		logic [7:0] second_pixel;
		logic [1:0] status;
		logic       last;
	} out_t;

	// Work for the back end. A kind of ST_PAIR means a stored row.
	typedef struct packed {
		logic [1:0]        kind;
		logic              bank;
		logic [COLS_W-1:0] count;
		logic              with_end;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [COLS_W-1:0] slot;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic done;
		logic bank;
	} done_t;

endpackage

// File: rtl/csvp_cmd_fifo.sv
`timescale 1ns / 1ps
module csvp_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csvp_pkg::cmd_t    push_data,
	output logic              full,
	input  logic              pop,
	output csvp_pkg::cmd_t    pop_data,
	output logic              empty
);

	csvp_pkg::cmd_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full = (fill_q == 2'd2);
	assign empty = (fill_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/csvp_front.sv
`timescale 1ns / 1ps
module csvp_front #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  csvp_pkg::in_t                 item,
	input  logic [csvp_pkg::COLS_W-1:0]   columns,
	output logic                          q_push,
	output csvp_pkg::cmd_t                q_data,
	input  logic                          q_full,
	output csvp_pkg::wr_t                 wr,
	input  csvp_pkg::done_t               done
);

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_NUMBER = 2'd1;
	localparam logic [1:0] PH_AFTER = 2'd2;
	localparam logic [1:0] PH_DROP = 2'd3;
	localparam logic [csvp_pkg::COLS_W-1:0] MAX_C = csvp_pkg::COLS_W'(MAX_COLUMNS);

	logic [csvp_pkg::COLS_W-1:0] count_q;
	logic [1:0]  phase_q;
	logic        blank_q;
	logic [31:0] acc_q;
	logic        pend_cr_q;
	logic        halted_q;
	logic        bank_q;
	logic [1:0]  busy_q;

	logic [csvp_pkg::COLS_W-1:0] count_n;
	logic [csvp_pkg::COLS_W-1:0] count_inc;
	logic [csvp_pkg::COLS_W-1:0] cnt_eff;
	logic [1:0]  phase_n;
	logic        blank_n;
	logic [31:0] acc_n;
	logic        pend_n;
	logic        accept;
	logic [7:0]  c;
	logic        is_digit;
	logic        is_blank;
	logic        is_comma;
	logic [31:0] digit;
	logic        acc_big;
	logic [35:0] acc10;
	logic        fatal_val;
	logic        fatal_wid;
	logic        row;
	logic        keep;
	logic        close_wr;

	assign accept = item_valid && item_ready;
	assign item_ready = halted_q || (!q_full && !busy_q[bank_q]);
	assign c = item.byte_value;
	assign is_digit = (c >= csvp_pkg::CH_ZERO) && (c <= csvp_pkg::CH_NINE);
	assign is_blank = (c == csvp_pkg::CH_SPACE) || (c == csvp_pkg::CH_TAB);
	assign is_comma = (c == csvp_pkg::CH_COMMA);
	assign digit = {24'd0, c - csvp_pkg::CH_ZERO};
	assign acc_big = acc_q > csvp_pkg::VALUE_MAX;
	assign acc10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {4'd0, digit};
	assign count_inc = (count_q == csvp_pkg::COUNT_SAT) ? count_q : count_q + 7'd1;

	always_comb begin
		count_n = count_q;
		phase_n = phase_q;
		blank_n = blank_q;
		acc_n = acc_q;
		pend_n = pend_cr_q;
		cnt_eff = count_q;
		fatal_val = 1'b0;
		fatal_wid = 1'b0;
		row = 1'b0;
		keep = 1'b1;
		close_wr = 1'b0;
		if (accept && !halted_q) begin
			if (item.end_of_stream || c == csvp_pkg::CH_LF) begin
				unique case (phase_q)
					PH_NUMBER: begin
						if (acc_big) begin
							fatal_val = 1'b1;
						end else begin
							close_wr = 1'b1;
							cnt_eff = count_inc;
						end
					end
					PH_DROP: keep = 1'b0;
					PH_START: keep = !blank_q;
					default: keep = 1'b1;
				endcase
				if (!fatal_val && keep && cnt_eff != '0) begin
					if (cnt_eff != columns || columns > MAX_C) begin
						fatal_wid = 1'b1;
					end else begin
						row = 1'b1;
					end
				end
				count_n = '0;
				phase_n = PH_START;
				blank_n = 1'b0;
				acc_n = '0;
				pend_n = 1'b0;
			end else if (pend_cr_q) begin
				if (phase_q == PH_NUMBER && acc_big) begin
					fatal_val = 1'b1;
				end else begin
					phase_n = PH_DROP;
				end
				pend_n = (c == csvp_pkg::CH_CR);
			end else if (c == csvp_pkg::CH_CR) begin
				pend_n = 1'b1;
			end else begin
				unique case (phase_q)
					PH_NUMBER: begin
						if (is_digit) begin
							if (acc10[35:32] != 4'd0) begin
								phase_n = PH_DROP;
							end else begin
								acc_n = acc10[31:0];
							end
						end else if (acc_big) begin
							fatal_val = 1'b1;
						end else begin
							close_wr = 1'b1;
							count_n = count_inc;
							if (is_blank) begin
								phase_n = PH_AFTER;
							end else if (is_comma) begin
								phase_n = PH_START;
								blank_n = 1'b0;
							end else begin
								phase_n = PH_DROP;
							end
						end
					end
					PH_START: begin
						if (is_digit) begin
							acc_n = digit;
							phase_n = PH_NUMBER;
						end else if (is_blank) begin
							blank_n = 1'b1;
						end else begin
							phase_n = PH_DROP;
						end
					end
					PH_AFTER: begin
						if (is_digit) begin
							acc_n = digit;
							phase_n = PH_NUMBER;
						end else if (is_comma) begin
							phase_n = PH_START;
							blank_n = 1'b0;
						end else if (!is_blank) begin
							phase_n = PH_DROP;
						end
					end
					default: phase_n = PH_DROP;
				endcase
			end
		end
	end

	always_comb begin
		q_push = row || fatal_val || fatal_wid || (accept && !halted_q && item.end_of_stream);
		q_data.bank = bank_q;
		q_data.count = cnt_eff;
		q_data.with_end = item.end_of_stream;
		if (fatal_val) begin
			q_data.kind = csvp_pkg::ST_VALUE;
		end else if (fatal_wid) begin
			q_data.kind = csvp_pkg::ST_WIDTH;
		end else if (row) begin
			q_data.kind = csvp_pkg::ST_PAIR;
		end else begin
			q_data.kind = csvp_pkg::ST_END;
		end
		wr.en = close_wr && (count_q < MAX_C);
		wr.bank = bank_q;
		wr.slot = count_q;
		wr.data = acc_q[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= PH_START;
			blank_q <= 1'b0;
			acc_q <= '0;
			pend_cr_q <= 1'b0;
			halted_q <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= 2'b00;
		end else begin
			count_q <= count_n;
			phase_q <= phase_n;
			blank_q <= blank_n;
			acc_q <= acc_n;
			pend_cr_q <= pend_n;
			if (fatal_val || fatal_wid || (accept && !halted_q && item.end_of_stream)) begin
				halted_q <= 1'b1;
			end
			if (row) begin
				bank_q <= ~bank_q;
			end
			for (int b = 0; b < 2; b++) begin
				if (row && bank_q == b[0]) begin
					busy_q[b] <= 1'b1;
				end else if (done.done && done.bank == b[0]) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/csvp_back.sv
`timescale 1ns / 1ps
module csvp_back #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  csvp_pkg::cmd_t    q_data,
	output logic              q_pop,
	input  csvp_pkg::wr_t     wr,
	output csvp_pkg::done_t   done,
	output logic              result_valid,
	input  logic              result_ready,
	output csvp_pkg::out_t    result
);

	localparam int PAIRS = (MAX_COLUMNS + 1) / 2;
	localparam int PIW = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int DEPTH = 2 ** (PIW + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_PAIR = 2'd2;
	localparam logic [1:0] S_STAT = 2'd3;

	logic [7:0] even_mem [DEPTH];
	logic [7:0] odd_mem [DEPTH];

	logic [1:0]     state_q;
	csvp_pkg::cmd_t cmd_q;
	logic [PIW-1:0] pidx_q;
	logic [1:0]     stat_q;
	logic [7:0]     rd_even_q;
	logic [7:0]     rd_odd_q;

	logic [csvp_pkg::COLS_W-1:0] half;
	logic [PIW:0]   wr_addr;
	logic [PIW:0]   rd_addr;
	logic [7:0]     pos;
	logic [7:0]     cnt8;
	logic           last_pair;
	logic           pad;
	logic           xfer;

	assign half = {1'b0, wr.slot[csvp_pkg::COLS_W-1:1]};
	assign wr_addr = {wr.bank, half[PIW-1:0]};
	assign rd_addr = {cmd_q.bank, pidx_q};
	assign pos = 8'({pidx_q, 1'b0});
	assign cnt8 = {1'b0, cmd_q.count};
	assign last_pair = (pos + 8'd2) >= cnt8;
	assign pad = (pos + 8'd1) >= cnt8;
	assign xfer = result_valid && result_ready;
	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign done.done = (state_q == S_PAIR) && xfer && last_pair;
	assign done.bank = cmd_q.bank;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			if (wr.slot[0]) begin
				odd_mem[wr_addr] <= wr.data;
			end else begin
				even_mem[wr_addr] <= wr.data;
			end
		end
		rd_even_q <= even_mem[rd_addr];
		rd_odd_q <= odd_mem[rd_addr];
	end

	always_comb begin
		result_valid = (state_q == S_PAIR) || (state_q == S_STAT);
		if (state_q == S_PAIR) begin
			result.first_pixel = rd_even_q;
			result.second_pixel = pad ? 8'd0 : rd_odd_q;
			result.status = csvp_pkg::ST_PAIR;
			result.last = last_pair && !cmd_q.with_end;
		end else begin
			result.first_pixel = 8'd0;
			result.second_pixel = 8'd0;
			result.status = stat_q;
			result.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			pidx_q <= '0;
			stat_q <= csvp_pkg::ST_PAIR;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q <= q_data;
						pidx_q <= '0;
						stat_q <= q_data.kind;
						state_q <= (q_data.kind == csvp_pkg::ST_PAIR) ? S_READ : S_STAT;
					end
				end
				S_READ: state_q <= S_PAIR;
				S_PAIR: begin
					if (xfer) begin
						if (last_pair) begin
							stat_q <= csvp_pkg::ST_END;
							state_q <= cmd_q.with_end ? S_STAT : S_IDLE;
						end else begin
							pidx_q <= pidx_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_STAT: begin
					if (xfer) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/csv_byte_row_parser.sv
`timescale 1ns / 1ps
// CSV row parser: one text byte is accepted per cycle as long as the two-entry command
// queue has room and the row bank being filled is not still being read out; a bank is
// held while its row drains, so a second row can be parsed in the other bank meanwhile.
// A row of N cells leaves as ceil(N/2) pairs, each fetched in an S_READ state through the
// registered read port of the row memory; a status result is shown the cycle after it
// leaves the queue. Each row is read only where it was written, so the memory needs no
// clearing pass after reset. The columns register is written with cfg_we and cfg_wdata.
module csv_byte_row_parser #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  csvp_pkg::in_t                 item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output csvp_pkg::out_t                result,
	input  logic                          cfg_we,
	input  logic [csvp_pkg::COLS_W-1:0]   cfg_wdata
);

	logic [csvp_pkg::COLS_W-1:0] columns_q;
	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	csvp_pkg::cmd_t  q_in;
	csvp_pkg::cmd_t  q_out;
	csvp_pkg::wr_t   wr;
	csvp_pkg::done_t done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= csvp_pkg::COLS_RESET;
		end else if (cfg_we) begin
			columns_q <= cfg_wdata;
		end
	end

	csvp_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.columns(columns_q),
		.q_push(q_push),
		.q_data(q_in),
		.q_full(q_full),
		.wr(wr),
		.done(done)
	);

	csvp_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_in),
		.full(q_full),
		.pop(q_pop),
		.pop_data(q_out),
		.empty(q_empty)
	);

	csvp_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(q_out),
		.q_pop(q_pop),
		.wr(wr),
		.done(done),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (wr.slot < csvp_pkg::COLS_W'(MAX_COLUMNS)))
		else $error("row store written beyond its depth");

	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != csvp_pkg::ST_PAIR) |->
		(result.last && result.first_pixel == 8'd0 && result.second_pixel == 8'd0))
		else $error("status result carries data or is not final");

endmodule
